[rtl/clrx_pkg.sv]
package clrx_pkg;

    // Parser position, including partial marker matches
    typedef enum logic [3:0] {
        PH_REC0  = 4'd0,
        PH_REC1  = 4'd1,
        PH_REC2  = 4'd2,
        PH_REC3  = 4'd3,
        PH_SKIP  = 4'd4,
        PH_CHAT0 = 4'd5,
        PH_CHAT1 = 4'd6,
        PH_HASH  = 4'd7,
        PH_MEM1  = 4'd8,
        PH_SEP   = 4'd9,
        PH_MEM2  = 4'd10,
        PH_MSG0  = 4'd11,
        PH_MSG1  = 4'd12,
        PH_BODY  = 4'd13
    } t_phase;

    localparam logic [7:0] REC_MARK_A    = 8'h6C;
    localparam logic [7:0] REC_MARK_B    = 8'h33;
    localparam logic [7:0] CHAT_MARK_A   = 8'hE0;
    localparam logic [7:0] TAG_LOW       = 8'h03;
    localparam logic [7:0] HASH_MARK     = 8'h23;
    localparam logic [7:0] MEMBER1_STOP  = 8'h2F;
    localparam logic [7:0] MEMBER2_STOP  = 8'h3B;
    localparam logic [7:0] MSG_MARK_A    = 8'hFC;
    localparam logic [7:0] NUL_BYTE      = 8'h00;
    localparam logic [7:0] SKIP_COUNT_RST = 8'd14;

    localparam logic [1:0] KIND_MEMBER1 = 2'd0;
    localparam logic [1:0] KIND_MEMBER2 = 2'd1;
    localparam logic [1:0] KIND_MESSAGE = 2'd2;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  skip_left;
        logic        muted;
    } t_state;

    typedef struct packed {
        logic        record_abort;
        logic        stream_end;
        logic        field_end;
        logic [1:0]  field_kind;
        logic        byte_valid;
        logic [7:0]  out_byte;
    } t_result;

endpackage

[rtl/clrx_step.sv]
// One parser step: next state and result for one byte.
module clrx_step (
    input  clrx_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [7:0]        i_skip_count,
    output clrx_pkg::t_state  o_state,
    output clrx_pkg::t_result o_result,
    output logic              o_emit
);

    clrx_pkg::t_state  w_nx;
    clrx_pkg::t_result w_res;
    logic              w_emit;
    logic [7:0]        w_skip_dec;
    logic [1:0]        w_kind;
    logic [7:0]        w_stop;

    assign w_skip_dec = i_state.skip_left - 8'd1;
    assign w_kind = (i_state.phase == clrx_pkg::PH_MEM1) ? clrx_pkg::KIND_MEMBER1
                                                         : clrx_pkg::KIND_MEMBER2;
    assign w_stop = (i_state.phase == clrx_pkg::PH_MEM1) ? clrx_pkg::MEMBER1_STOP
                                                         : clrx_pkg::MEMBER2_STOP;

    always_comb begin
        w_nx   = i_state;
        w_res  = '0;
        w_emit = 1'b0;
        case (i_state.phase)
            clrx_pkg::PH_REC2: begin
                if (i_byte == clrx_pkg::REC_MARK_B) begin
                    w_nx.phase = clrx_pkg::PH_REC3;
                end else if (i_byte == clrx_pkg::REC_MARK_A) begin
                    w_nx.phase = clrx_pkg::PH_REC1;
                end else begin
                    w_nx.phase = clrx_pkg::PH_REC0;
                end
            end
            clrx_pkg::PH_REC3: begin
                if (i_byte == clrx_pkg::REC_MARK_A) begin
                    if (i_skip_count == 8'd0) begin
                        w_nx.phase = clrx_pkg::PH_CHAT0;
                    end else begin
                        w_nx.skip_left = i_skip_count;
                        w_nx.phase     = clrx_pkg::PH_SKIP;
                    end
                end else begin
                    w_nx.phase = clrx_pkg::PH_REC0;
                end
            end
            clrx_pkg::PH_SKIP: begin
                w_nx.skip_left = w_skip_dec;
                if (w_skip_dec == 8'd0) begin
                    w_nx.phase = clrx_pkg::PH_CHAT0;
                end
            end
            clrx_pkg::PH_CHAT0: begin
                if (i_byte == clrx_pkg::CHAT_MARK_A) begin
                    w_nx.phase = clrx_pkg::PH_CHAT1;
                end
            end
            clrx_pkg::PH_CHAT1: begin
                if (i_byte == clrx_pkg::TAG_LOW) begin
                    w_nx.phase = clrx_pkg::PH_HASH;
                end else if (i_byte == clrx_pkg::CHAT_MARK_A) begin
                    w_nx.phase = clrx_pkg::PH_CHAT1;
                end else begin
                    w_nx.phase = clrx_pkg::PH_CHAT0;
                end
            end
            clrx_pkg::PH_HASH: begin
                if (i_byte == clrx_pkg::HASH_MARK) begin
                    w_nx.phase = clrx_pkg::PH_MEM1;
                    w_nx.muted = 1'b0;
                end
            end
            clrx_pkg::PH_MEM1, clrx_pkg::PH_MEM2: begin
                if (i_byte == w_stop) begin
                    w_res.field_kind = w_kind;
                    w_res.field_end  = 1'b1;
                    w_emit           = 1'b1;
                    w_nx.muted       = 1'b0;
                    w_nx.phase       = (i_state.phase == clrx_pkg::PH_MEM1)
                                       ? clrx_pkg::PH_SEP : clrx_pkg::PH_MSG0;
                end else if (i_byte == clrx_pkg::NUL_BYTE) begin
                    w_nx.muted = 1'b1;
                end else if (!i_state.muted) begin
                    w_res.out_byte   = i_byte;
                    w_res.byte_valid = 1'b1;
                    w_res.field_kind = w_kind;
                    w_emit           = 1'b1;
                end
            end
            clrx_pkg::PH_SEP: begin
                w_nx.phase = clrx_pkg::PH_MEM2;
                w_nx.muted = 1'b0;
            end
            clrx_pkg::PH_MSG0: begin
                if (i_byte == clrx_pkg::MSG_MARK_A) begin
                    w_nx.phase = clrx_pkg::PH_MSG1;
                end
            end
            clrx_pkg::PH_MSG1: begin
                if (i_byte == clrx_pkg::TAG_LOW) begin
                    w_nx.phase = clrx_pkg::PH_BODY;
                end else if (i_byte == clrx_pkg::MSG_MARK_A) begin
                    w_nx.phase = clrx_pkg::PH_MSG1;
                end else begin
                    w_nx.phase = clrx_pkg::PH_MSG0;
                end
            end
            clrx_pkg::PH_BODY: begin
                w_res.field_kind = clrx_pkg::KIND_MESSAGE;
                w_emit           = 1'b1;
                if (i_byte == clrx_pkg::NUL_BYTE) begin
                    w_res.field_end = 1'b1;
                    w_nx.phase      = clrx_pkg::PH_REC0;
                end else begin
                    w_res.out_byte   = i_byte;
                    w_res.byte_valid = 1'b1;
                end
            end
            default: begin
                // first two seeking phases and any unused code
                if (i_byte == clrx_pkg::REC_MARK_A) begin
                    w_nx.phase = clrx_pkg::PH_REC1;
                end else if (i_byte == clrx_pkg::REC_MARK_B &&
                             i_state.phase == clrx_pkg::PH_REC1) begin
                    w_nx.phase = clrx_pkg::PH_REC2;
                end else begin
                    w_nx.phase = clrx_pkg::PH_REC0;
                end
            end
        endcase
    end

    always_comb begin
        o_state  = w_nx;
        o_result = w_res;
        o_emit   = w_emit;
        if (i_last) begin
            o_emit                = 1'b1;
            o_result.stream_end   = 1'b1;
            o_result.record_abort = (w_nx.phase >= clrx_pkg::PH_SKIP);
            o_state.phase         = clrx_pkg::PH_REC0;
            o_state.skip_left     = 8'd0;
            o_state.muted         = 1'b0;
        end
    end

endmodule

[rtl/chat_log_record_extractor.sv]
// Chat log record extractor. Bytes enter one per beat on the slave side; the
// parser hunts for the record marker 6C 33 33 6C, passes over skip_count
// bytes, finds E0 03 then 23, and returns the first member (up to 2F), the
// second member (after one passed-over byte, up to 3B) and, after FC 03, the
// message (up to a zero byte). Each field byte leaves as one master beat
// tagged by field kind, and each field closes with an end beat carrying no
// byte. Marker, skipped and muted bytes produce no beat, except the final
// byte of the stream, which always produces exactly one beat with tlast set;
// record_abort on that beat says the record was cut short. The block takes
// one byte per clock unless stalled: the parser updates its phase on
// acceptance and the result enters the output register on the next cycle.
// The slave side stalls only while a result is held and the master side is
// not ready. The user must write skip_count through the config port only
// while the stream is idle (unchecked); a completed record marker latches it.
module chat_log_record_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,      // skip_count
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]  o_m_axis_tuser,   // [0] byte_valid, [2:1] field_kind,
                                          // [3] field_end, [4] record_abort
    output logic        o_m_axis_tlast    // stream_end
);

    clrx_pkg::t_state  r_state;
    clrx_pkg::t_state  n_state;
    logic [7:0]        r_skip_count;
    clrx_pkg::t_result r_out;
    clrx_pkg::t_result n_out;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_emit;
    logic              w_accept;

    // Accept a new byte whenever the output register is free or being drained
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    clrx_step u_step (
        .i_state      (r_state),
        .i_byte       (i_s_axis_tdata),
        .i_last       (i_s_axis_tlast),
        .i_skip_count (r_skip_count),
        .o_state      (n_state),
        .o_result     (n_out),
        .o_emit       (w_emit)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        // drop the held beat once taken
        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        // load a fresh result beat
        if (w_accept && w_emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= clrx_pkg::PH_REC0;
            r_state.skip_left <= 8'd0;
            r_state.muted     <= 1'b0;
            r_skip_count      <= clrx_pkg::SKIP_COUNT_RST;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_skip_count <= i_cfg_wdata;
            end
            // advance the parser on every accepted beat
            if (w_accept) begin
                r_state <= n_state;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Payload register: hold while stalled, load on an emitting beat
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.out_byte;
    assign o_m_axis_tuser  = {r_out.record_abort, r_out.field_end,
                              r_out.field_kind, r_out.byte_valid};
    assign o_m_axis_tlast  = r_out.stream_end;

endmodule

[tb/sv/testbench.sv]
// Field extraction predictor and result checker for the chat log extractor.
class field_scoreboard;
    clrx_pkg::t_phase  phase;
    logic [7:0]        skip_left;
    logic [7:0]        skip_count;
    bit                muted;
    clrx_pkg::t_result pending_fields[$];
    int                errors;
    int                beats_seen;

    function new();
        phase = clrx_pkg::PH_REC0;
        skip_left = '0;
        skip_count = clrx_pkg::SKIP_COUNT_RST;
        muted = 0;
        errors = 0;
        beats_seen = 0;
    endfunction

    function void write_skip(logic [7:0] value);
        skip_count = value;
    endfunction

    function int outstanding();
        return pending_fields.size();
    endfunction

    // Advance the parser by one accepted byte and queue the beat it causes.
    function void accept_byte(logic [7:0] b, logic last);
        clrx_pkg::t_result r;
        bit                emit;
        logic [1:0]        kind;
        logic [7:0]        stop;
        r = '0;
        emit = 0;
        case (phase)
            clrx_pkg::PH_REC0, clrx_pkg::PH_REC1: begin
                phase = (b == clrx_pkg::REC_MARK_A) ? clrx_pkg::PH_REC1 :
                        (b == clrx_pkg::REC_MARK_B && phase == clrx_pkg::PH_REC1)
                        ? clrx_pkg::PH_REC2 : clrx_pkg::PH_REC0;
            end
            clrx_pkg::PH_REC2: begin
                phase = (b == clrx_pkg::REC_MARK_B) ? clrx_pkg::PH_REC3 :
                        (b == clrx_pkg::REC_MARK_A) ? clrx_pkg::PH_REC1 : clrx_pkg::PH_REC0;
            end
            clrx_pkg::PH_REC3: begin
                if (b == clrx_pkg::REC_MARK_A) begin
                    if (skip_count == 8'd0) begin
                        phase = clrx_pkg::PH_CHAT0;
                    end else begin
                        skip_left = skip_count;
                        phase = clrx_pkg::PH_SKIP;
                    end
                end else begin
                    phase = clrx_pkg::PH_REC0;
                end
            end
            clrx_pkg::PH_SKIP: begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'd0) phase = clrx_pkg::PH_CHAT0;
            end
            clrx_pkg::PH_CHAT0: begin
                if (b == clrx_pkg::CHAT_MARK_A) phase = clrx_pkg::PH_CHAT1;
            end
            clrx_pkg::PH_CHAT1: begin
                phase = (b == clrx_pkg::TAG_LOW) ? clrx_pkg::PH_HASH :
                        (b == clrx_pkg::CHAT_MARK_A) ? clrx_pkg::PH_CHAT1 : clrx_pkg::PH_CHAT0;
            end
            clrx_pkg::PH_HASH: begin
                if (b == clrx_pkg::HASH_MARK) begin
                    phase = clrx_pkg::PH_MEM1;
                    muted = 0;
                end
            end
            clrx_pkg::PH_MEM1, clrx_pkg::PH_MEM2: begin
                kind = (phase == clrx_pkg::PH_MEM1) ? clrx_pkg::KIND_MEMBER1
                                                    : clrx_pkg::KIND_MEMBER2;
                stop = (phase == clrx_pkg::PH_MEM1) ? clrx_pkg::MEMBER1_STOP
                                                    : clrx_pkg::MEMBER2_STOP;
                if (b == stop) begin
                    r.field_kind = kind;
                    r.field_end = 1'b1;
                    emit = 1;
                    muted = 0;
                    phase = (phase == clrx_pkg::PH_MEM1) ? clrx_pkg::PH_SEP
                                                         : clrx_pkg::PH_MSG0;
                end else if (b == clrx_pkg::NUL_BYTE) begin
                    muted = 1;
                end else if (!muted) begin
                    r.out_byte = b;
                    r.byte_valid = 1'b1;
                    r.field_kind = kind;
                    emit = 1;
                end
            end
            clrx_pkg::PH_SEP: begin
                phase = clrx_pkg::PH_MEM2;
                muted = 0;
            end
            clrx_pkg::PH_MSG0: begin
                if (b == clrx_pkg::MSG_MARK_A) phase = clrx_pkg::PH_MSG1;
            end
            clrx_pkg::PH_MSG1: begin
                phase = (b == clrx_pkg::TAG_LOW) ? clrx_pkg::PH_BODY :
                        (b == clrx_pkg::MSG_MARK_A) ? clrx_pkg::PH_MSG1 : clrx_pkg::PH_MSG0;
            end
            default: begin
                emit = 1;
                r.field_kind = clrx_pkg::KIND_MESSAGE;
                if (b == clrx_pkg::NUL_BYTE) begin
                    r.field_end = 1'b1;
                    phase = clrx_pkg::PH_REC0;
                end else begin
                    r.out_byte = b;
                    r.byte_valid = 1'b1;
                end
            end
        endcase
        if (last) begin
            r.stream_end = 1'b1;
            r.record_abort = (phase >= clrx_pkg::PH_SKIP);
            phase = clrx_pkg::PH_REC0;
            skip_left = '0;
            muted = 0;
            emit = 1;
        end
        if (emit) pending_fields.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("tb: mismatch at beat %0d: %s got %0h want %0h",
                 beats_seen, what, got, want);
        errors++;
    endtask

    task check_beat(clrx_pkg::t_result got);
        clrx_pkg::t_result want;
        if (pending_fields.size() == 0) begin
            report_mismatch("beat with nothing expected", 0, 0);
        end else begin
            want = pending_fields.pop_front();
            if (got.out_byte != want.out_byte)
                report_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.byte_valid != want.byte_valid)
                report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
            if (got.field_kind != want.field_kind)
                report_mismatch("field_kind", got.field_kind, want.field_kind);
            if (got.field_end != want.field_end)
                report_mismatch("field_end", got.field_end, want.field_end);
            if (got.stream_end != want.stream_end)
                report_mismatch("stream_end", got.stream_end, want.stream_end);
            if (got.record_abort != want.record_abort)
                report_mismatch("record_abort", got.record_abort, want.record_abort);
        end
        beats_seen++;
    endtask
endclass

module testbench;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_log_byte;

    localparam int STALL_LIMIT = 2000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = '0;
    logic       i_s_axis_tlast = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;
    logic [4:0] o_m_axis_tuser;
    logic       o_m_axis_tlast;

    field_scoreboard fields = new();
    t_log_byte       byte_feed[$];
    int              send_idle_pct = 15;
    int              recv_idle_pct = 72;
    int              quiet_cycles = 0;
    int              skip_setting = clrx_pkg::SKIP_COUNT_RST;

    chat_log_record_extractor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: stall at random, one decision per falling edge.
    always @(negedge i_clk) begin
        i_m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: feed accepted bytes to the predictor, check accepted beats,
    // and watch for a hung handshake.
    always @(posedge i_clk) begin
        clrx_pkg::t_result beat;
        if (i_rst_n) begin
            if (i_cfg_we) fields.write_skip(i_cfg_wdata);
            if (i_s_axis_tvalid && o_s_axis_tready)
                fields.accept_byte(i_s_axis_tdata, i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                beat.out_byte = o_m_axis_tdata;
                beat.byte_valid = o_m_axis_tuser[0];
                beat.field_kind = o_m_axis_tuser[2:1];
                beat.field_end = o_m_axis_tuser[3];
                beat.record_abort = o_m_axis_tuser[4];
                beat.stream_end = o_m_axis_tlast;
                fields.check_beat(beat);
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function void push_byte(logic [7:0] b, logic last);
        t_log_byte item;
        item.data = b;
        item.last = last;
        byte_feed.push_back(item);
    endfunction

    // Random field content: any byte value, sometimes an embedded zero,
    // never the byte that would close the field.
    function automatic logic [7:0] content_byte(logic [7:0] stop);
        logic [7:0] b;
        b = ($urandom_range(0, 99) < 6) ? clrx_pkg::NUL_BYTE : 8'($urandom_range(0, 255));
        if (b == stop) b = stop ^ 8'h01;
        return b;
    endfunction

    // Queue well-formed records with random content, plus noise and
    // records cut short, until the byte budget is spent.
    task build_records(int budget);
        logic [7:0] rec[$];
        int         added;
        int         n;
        int         cut;
        added = 0;
        while (added < budget) begin
            rec.delete();
            n = $urandom_range(0, 3);
            repeat (n) rec.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0) begin
                rec.push_back(clrx_pkg::REC_MARK_A);
                rec.push_back(clrx_pkg::REC_MARK_B);
            end
            rec.push_back(clrx_pkg::REC_MARK_A);
            rec.push_back(clrx_pkg::REC_MARK_B);
            rec.push_back(clrx_pkg::REC_MARK_B);
            rec.push_back(clrx_pkg::REC_MARK_A);
            repeat (skip_setting) rec.push_back(8'($urandom_range(0, 255)));
            n = $urandom_range(0, 2);
            repeat (n) rec.push_back(content_byte(clrx_pkg::CHAT_MARK_A));
            if ($urandom_range(0, 4) == 0) rec.push_back(clrx_pkg::CHAT_MARK_A);
            rec.push_back(clrx_pkg::CHAT_MARK_A);
            rec.push_back(clrx_pkg::TAG_LOW);
            n = $urandom_range(0, 2);
            repeat (n) rec.push_back(content_byte(clrx_pkg::HASH_MARK));
            rec.push_back(clrx_pkg::HASH_MARK);
            n = $urandom_range(0, 8);
            repeat (n) rec.push_back(content_byte(clrx_pkg::MEMBER1_STOP));
            rec.push_back(clrx_pkg::MEMBER1_STOP);
            rec.push_back(($urandom_range(0, 2) == 0) ? clrx_pkg::MEMBER2_STOP
                                                       : 8'($urandom_range(0, 255)));
            n = $urandom_range(0, 8);
            repeat (n) rec.push_back(content_byte(clrx_pkg::MEMBER2_STOP));
            rec.push_back(clrx_pkg::MEMBER2_STOP);
            n = $urandom_range(0, 2);
            repeat (n) rec.push_back(content_byte(clrx_pkg::MSG_MARK_A));
            if ($urandom_range(0, 4) == 0) rec.push_back(clrx_pkg::MSG_MARK_A);
            rec.push_back(clrx_pkg::MSG_MARK_A);
            rec.push_back(clrx_pkg::TAG_LOW);
            n = $urandom_range(0, 12);
            repeat (n) rec.push_back(8'($urandom_range(1, 255)));
            rec.push_back(clrx_pkg::NUL_BYTE);
            // Break about one record in five at a random point.
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, rec.size() - 1);
                while (rec.size() > cut) void'(rec.pop_back());
            end
            for (int i = 0; i < rec.size(); i++)
                push_byte(rec[i], (i == rec.size() - 1) && ($urandom_range(0, 3) == 0));
            added += rec.size();
        end
        byte_feed[byte_feed.size() - 1].last = 1'b1;
    endtask

    // Drive queued bytes on the slave side; hold each until it is accepted.
    task send_stream();
        t_log_byte item;
        while (byte_feed.size() != 0) begin
            @(negedge i_clk);
            if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata <= 8'($urandom_range(0, 255));
            end else begin
                item = byte_feed.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= item.data;
                i_s_axis_tlast <= item.last;
                do @(posedge i_clk); while (!o_s_axis_tready);
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    // Wait for every expected beat, then give bytes in flight that produce
    // nothing time to pass through.
    task settle();
        while (fields.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_skip_count(logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        skip_setting = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int skip_plan[6];
        skip_plan = '{3, 14, 255, 1, 7, 0};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Overlapping marker starts with the reset skip count, then the
        // stream ends inside the skip window: the record must be dropped.
        push_byte(clrx_pkg::REC_MARK_A, 1'b0);
        push_byte(clrx_pkg::REC_MARK_B, 1'b0);
        push_byte(clrx_pkg::REC_MARK_A, 1'b0);
        push_byte(clrx_pkg::REC_MARK_B, 1'b0);
        push_byte(clrx_pkg::REC_MARK_B, 1'b0);
        push_byte(clrx_pkg::REC_MARK_A, 1'b0);
        push_byte(8'hFF, 1'b1);
        // A partial marker at stream end is no record.
        push_byte(clrx_pkg::REC_MARK_A, 1'b0);
        push_byte(clrx_pkg::REC_MARK_B, 1'b1);
        send_stream();
        settle();

        // No skip: full record with a muted member, a separator that looks
        // like a member stop, repeated tag leads and an empty second member.
        write_skip_count(8'd0);
        push_byte(clrx_pkg::REC_MARK_A, 1'b0);
        push_byte(clrx_pkg::REC_MARK_B, 1'b0);
        push_byte(clrx_pkg::REC_MARK_B, 1'b0);
        push_byte(clrx_pkg::REC_MARK_A, 1'b0);
        push_byte(clrx_pkg::CHAT_MARK_A, 1'b0);
        push_byte(clrx_pkg::CHAT_MARK_A, 1'b0);
        push_byte(clrx_pkg::TAG_LOW, 1'b0);
        push_byte(clrx_pkg::HASH_MARK, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(clrx_pkg::NUL_BYTE, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(clrx_pkg::MEMBER1_STOP, 1'b0);
        push_byte(clrx_pkg::MEMBER2_STOP, 1'b0);
        push_byte(clrx_pkg::MEMBER2_STOP, 1'b0);
        push_byte(clrx_pkg::MSG_MARK_A, 1'b0);
        push_byte(clrx_pkg::MSG_MARK_A, 1'b0);
        push_byte(clrx_pkg::TAG_LOW, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(clrx_pkg::NUL_BYTE, 1'b0);
        push_byte(clrx_pkg::NUL_BYTE, 1'b1);
        send_stream();

        // Random records under three idle patterns, two skip settings each.
        for (int mode = 0; mode < 3; mode++) begin
            for (int sub = 0; sub < 2; sub++) begin
                settle();
                if (sub == 0) begin
                    send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 72 : 0;
                    recv_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 15 : 0;
                end
                write_skip_count(8'(skip_plan[mode * 2 + sub]));
                build_records(305);
                send_stream();
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fields.errors == 0 && fields.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
